@@ sv/mlt_pkg.sv @@
// Shared types and constants of the MAC learning table with aging.
package mlt_pkg;

	localparam int MLT_ENTRIES = 64;
	localparam int MLT_PORTS   = 8;

	localparam int ADDR_W    = 48;
	localparam int PORT_W    = 3;
	localparam int TIME_W    = 32;
	localparam int PCOUNT_W  = 4;
	localparam int MASK_W    = 8;
	localparam int REMOVED_W = 7;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam logic [PCOUNT_W-1:0] FLOOD_MAX =
		PCOUNT_W'((MLT_PORTS < MASK_W) ? MLT_PORTS : MASK_W);
	localparam logic [REMOVED_W-1:0] REMOVED_MAX = '1;

	localparam logic [TIME_W-1:0]   TIMEOUT_RESET = 32'd300;
	localparam logic [PCOUNT_W-1:0] PCOUNT_RESET  = 4'd8;

	typedef enum logic [1:0] {
		OP_LEARN  = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_PURGE  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_REFRESHED = 3'd0,
		ST_LEARNED   = 3'd1,
		ST_FULL      = 3'd2,
		ST_HIT       = 3'd3,
		ST_MISS      = 3'd4,
		ST_PURGED    = 3'd5
	} status_t;

	typedef enum logic {
		REG_TIMEOUT = 1'b0,
		REG_PCOUNT  = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_LAST,
		S_COMMIT
	} state_t;

	typedef struct packed {
		logic [TIME_W-1:0]   age_limit;
		logic [PCOUNT_W-1:0] port_count;
	} cfg_t;

	typedef struct packed {
		logic                valid;
		logic [ADDR_W-1:0]   address;
		logic [PORT_W-1:0]   port;
		logic [TIME_W-1:0]   stamp;
	} entry_t;

	typedef struct packed {
		status_t              status;
		logic [PORT_W-1:0]    out_port;
		logic [MASK_W-1:0]    flood_mask;
		logic [REMOVED_W-1:0] removed_count;
	} result_t;

endpackage

@@ sv/mlt_cfg.sv @@
// Configuration register bank with APB-style access.
module mlt_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mlt_pkg::PADDR_W-1:0]   paddr,
	input  logic [mlt_pkg::PDATA_W-1:0]   pwdata,
	output logic [mlt_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output mlt_pkg::cfg_t                 cfg
);

	mlt_pkg::cfg_t cfg_q;
	logic          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.age_limit  <= mlt_pkg::TIMEOUT_RESET;
			cfg_q.port_count <= mlt_pkg::PCOUNT_RESET;
		end else if (wr_en) begin
			case (mlt_pkg::reg_idx_t'(paddr[2]))
				mlt_pkg::REG_TIMEOUT: begin
					cfg_q.age_limit <= pwdata;
				end
				mlt_pkg::REG_PCOUNT: begin
					cfg_q.port_count <= pwdata[mlt_pkg::PCOUNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (mlt_pkg::reg_idx_t'(paddr[2]))
			mlt_pkg::REG_TIMEOUT: prdata = cfg_q.age_limit;
			mlt_pkg::REG_PCOUNT:  prdata = mlt_pkg::PDATA_W'(cfg_q.port_count);
			default:              prdata = '0;
		endcase
	end

endmodule

@@ sv/mlt_scan.sv @@
// Table memory, walk sequencer and shared per-record compare unit.
module mlt_scan #(
	parameter int ENTRIES = mlt_pkg::MLT_ENTRIES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mlt_pkg::cfg_t                 cfg,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    op,
	input  logic [mlt_pkg::ADDR_W-1:0]    mac_address,
	input  logic [mlt_pkg::PORT_W-1:0]    port_number,
	input  logic [mlt_pkg::TIME_W-1:0]    now_seconds,
	output logic                          res_valid,
	input  logic                          res_take,
	output mlt_pkg::result_t              res
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

	mlt_pkg::state_t state_q, state_d;

	mlt_pkg::entry_t mem [ENTRIES];
	mlt_pkg::entry_t rdata_s1;
	logic            rd_vld_s1;
	logic [IW-1:0]   idx_s1;
	logic [IW-1:0]   rd_idx_q;

	logic                         mem_re;
	logic                         mem_we;
	logic [IW-1:0]                mem_wa;
	mlt_pkg::entry_t              mem_wd;

	logic [1:0]                   op_q;
	logic [mlt_pkg::ADDR_W-1:0]   addr_q;
	logic [mlt_pkg::PORT_W-1:0]   port_q;
	logic [mlt_pkg::TIME_W-1:0]   now_q;

	logic                         hit_q;
	logic [IW-1:0]                hit_idx_q;
	logic [mlt_pkg::PORT_W-1:0]   hit_port_q;
	logic                         free_q;
	logic [IW-1:0]                free_idx_q;
	logic [mlt_pkg::REMOVED_W-1:0] removed_q;

	logic                         in_accept;
	logic                         is_learn;
	logic                         is_purge;
	logic                         ent_match;
	logic                         ent_free;
	logic                         ent_aged;
	logic [mlt_pkg::TIME_W-1:0]   ent_age;
	logic [mlt_pkg::PCOUNT_W-1:0] flood_n;
	logic [mlt_pkg::MASK_W-1:0]   flood;

	assign in_stall  = (state_q != mlt_pkg::S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign is_learn  = (op_q == mlt_pkg::OP_LEARN);
	assign is_purge  = (op_q == mlt_pkg::OP_PURGE);

	// shared compare unit, one record per cycle
	assign ent_age   = now_q - rdata_s1.stamp;
	assign ent_match = rd_vld_s1 && rdata_s1.valid && (rdata_s1.address == addr_q);
	assign ent_free  = rd_vld_s1 && !rdata_s1.valid;
	assign ent_aged  = rd_vld_s1 && rdata_s1.valid && (ent_age > cfg.age_limit);

	always_comb begin
		flood_n = (cfg.port_count > mlt_pkg::FLOOD_MAX) ? mlt_pkg::FLOOD_MAX : cfg.port_count;
		for (int p = 0; p < mlt_pkg::MASK_W; p++) begin
			flood[p] = (mlt_pkg::PCOUNT_W'(p) < flood_n) && (mlt_pkg::PORT_W'(p) != port_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mlt_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mlt_pkg::S_CLEAR: begin
				if (rd_idx_q == LAST_IDX) begin
					state_d = mlt_pkg::S_IDLE;
				end
			end
			mlt_pkg::S_IDLE: begin
				if (in_accept) begin
					state_d = mlt_pkg::S_SCAN;
				end
			end
			mlt_pkg::S_SCAN: begin
				if (rd_idx_q == LAST_IDX) begin
					state_d = mlt_pkg::S_LAST;
				end
			end
			mlt_pkg::S_LAST: begin
				state_d = mlt_pkg::S_COMMIT;
			end
			mlt_pkg::S_COMMIT: begin
				if (res_take) begin
					state_d = mlt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = mlt_pkg::S_CLEAR;
			end
		endcase
	end

	always_comb begin
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_wa    = idx_s1;
		mem_wd    = rdata_s1;
		res_valid = 1'b0;
		res       = '0;
		case (state_q)
			mlt_pkg::S_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = rd_idx_q;
				mem_wd = '0;
			end
			mlt_pkg::S_SCAN, mlt_pkg::S_LAST: begin
				mem_re       = (state_q == mlt_pkg::S_SCAN);
				mem_we       = is_purge && ent_aged;
				mem_wa       = idx_s1;
				mem_wd       = rdata_s1;
				mem_wd.valid = 1'b0;
			end
			mlt_pkg::S_COMMIT: begin
				res_valid = 1'b1;
				mem_wd.valid     = 1'b1;
				mem_wd.address   = addr_q;
				mem_wd.stamp     = now_q;
				if (is_learn) begin
					if (hit_q) begin
						res.status     = mlt_pkg::ST_REFRESHED;
						mem_we         = res_take;
						mem_wa         = hit_idx_q;
						mem_wd.port    = hit_port_q;
					end else if (free_q) begin
						res.status     = mlt_pkg::ST_LEARNED;
						mem_we         = res_take;
						mem_wa         = free_idx_q;
						mem_wd.port    = port_q;
					end else begin
						res.status     = mlt_pkg::ST_FULL;
					end
				end else if (is_purge) begin
					res.status        = mlt_pkg::ST_PURGED;
					res.removed_count = removed_q;
				end else if (hit_q) begin
					res.status   = mlt_pkg::ST_HIT;
					res.out_port = hit_port_q;
				end else begin
					res.status     = mlt_pkg::ST_MISS;
					res.flood_mask = flood;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rdata_s1 <= mem[rd_idx_q];
		end
		idx_s1 <= rd_idx_q;
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q   <= op;
			addr_q <= mac_address;
			port_q <= port_number;
			now_q  <= now_seconds;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			rd_idx_q  <= '0;
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
			removed_q <= '0;
		end else begin
			rd_vld_s1 <= mem_re;
			if (in_accept) begin
				rd_idx_q  <= '0;
				hit_q     <= 1'b0;
				free_q    <= 1'b0;
				removed_q <= '0;
			end else begin
				if (state_q == mlt_pkg::S_CLEAR || state_q == mlt_pkg::S_SCAN) begin
					rd_idx_q <= (rd_idx_q == LAST_IDX) ? '0 : rd_idx_q + 1'b1;
				end
				if (ent_match && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (ent_free && !free_q) begin
					free_q <= 1'b1;
				end
				if (is_purge && ent_aged && removed_q != mlt_pkg::REMOVED_MAX) begin
					removed_q <= removed_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ent_match && !hit_q) begin
			hit_idx_q  <= idx_s1;
			hit_port_q <= rdata_s1.port;
		end
		if (ent_free && !free_q) begin
			free_idx_q <= idx_s1;
		end
	end

	a_accept_starts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (state_q == mlt_pkg::S_SCAN) && (rd_idx_q == '0))
		else $error("accepted transfer did not start a table walk at the first record");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q != mlt_pkg::S_IDLE))
		else $error("table written while idle");

	a_last_record: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mlt_pkg::S_LAST) |-> (rd_vld_s1 && idx_s1 == LAST_IDX))
		else $error("walk ended before the last record was compared");

	a_removed_only_purge: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == mlt_pkg::S_COMMIT) && (removed_q != '0)) |-> is_purge)
		else $error("removal counted outside a purge");

endmodule

@@ sv/mac_learning_table_with_aging.sv @@
// Top level of the MAC learning table with aging: config bank, table walker, result register.
// Each operation walks every record of the table through one read port, one record a cycle,
// with one shared compare unit; the walk runs through the SCAN and LAST states to COMMIT, and
// a new operation is taken once the result has moved into the output register. After reset
// a clearing pass writes every record, during which in_stall is high; configuration writes
// are taken throughout.
module mac_learning_table_with_aging #(
	parameter int ENTRIES = mlt_pkg::MLT_ENTRIES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mlt_pkg::PADDR_W-1:0]     paddr,
	input  logic [mlt_pkg::PDATA_W-1:0]     pwdata,
	output logic [mlt_pkg::PDATA_W-1:0]     prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      op,
	input  logic [mlt_pkg::ADDR_W-1:0]      mac_address,
	input  logic [mlt_pkg::PORT_W-1:0]      port_number,
	input  logic [mlt_pkg::TIME_W-1:0]      now_seconds,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [2:0]                      status,
	output logic [mlt_pkg::PORT_W-1:0]      out_port,
	output logic [mlt_pkg::MASK_W-1:0]      flood_mask,
	output logic [mlt_pkg::REMOVED_W-1:0]   removed_count
);

	mlt_pkg::cfg_t    cfg;
	mlt_pkg::result_t res;
	mlt_pkg::result_t res_q;
	logic             res_valid;
	logic             res_take;
	logic             out_valid_q;

	mlt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mlt_scan #(
		.ENTRIES (ENTRIES)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.mac_address (mac_address),
		.port_number (port_number),
		.now_seconds (now_seconds),
		.res_valid   (res_valid),
		.res_take    (res_take),
		.res         (res)
	);

	assign res_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = res_q.status;
	assign out_port      = res_q.out_port;
	assign flood_mask    = res_q.flood_mask;
	assign removed_count = res_q.removed_count;

endmodule
